>>> src/scpf_pkg.sv
package scpf_pkg;

   // Packet constants
   localparam logic [7:0]  HDR_HI = 8'hEF;
   localparam logic [7:0]  HDR_LO = 8'h01;
   localparam logic [31:0] DEVICE_ADDRESS_RESET = 32'hFFFF_FFFF;

   // Configuration space: one 32-bit register at byte address 0
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_DEVICE_ADDRESS = 1'b0;

   // Depth of the command queue between front and back
   localparam int CMD_DEPTH = 2;

   // Input item kinds
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_PARAM = 1'b1;

   // One classified job for the back end
   typedef struct packed {
      logic        is_start;
      logic [7:0]  flag;
      logic        len_hi;
      logic [7:0]  len_lo;
      logic [7:0]  data;
      logic        with_check;
      logic [15:0] sum;
   } scpf_cmd_type;

   // Back end sequencer: one state per byte position of a packet
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HDR_HI,
      ST_HDR_LO,
      ST_ADDR_3,
      ST_ADDR_2,
      ST_ADDR_1,
      ST_ADDR_0,
      ST_FLAG,
      ST_LEN_HI,
      ST_LEN_LO,
      ST_DATA,
      ST_SUM_HI,
      ST_SUM_LO
   } scpf_state_type;

endpackage

>>> src/scpf_front.sv
module scpf_front
   import scpf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic         func,
   input  logic [7:0]   data_byte,
   input  logic [7:0]   packet_flag,
   input  logic [7:0]   param_count,
   output logic         cmd_push,
   output scpf_cmd_type cmd
);

   logic        open_ff, open_in;
   logic [7:0]  left_ff, left_in;
   logic [15:0] sum_ff, sum_in;

   logic [8:0]  len;
   logic [15:0] start_sum;
   logic [15:0] param_sum;
   logic        last_param;

   assign len        = {1'b0, param_count} + 9'd3;
   assign start_sum  = 16'(packet_flag) + 16'(len[8]) + 16'(len[7:0]) + 16'(data_byte);
   assign param_sum  = sum_ff + 16'(data_byte);
   assign last_param = (left_ff == 8'd1);

   always_comb begin
      open_in  = open_ff;
      left_in  = left_ff;
      sum_in   = sum_ff;
      cmd_push = 1'b0;
      cmd      = '0;
      if (accept) begin
         if (func == FUNC_START) begin
            // a start abandons any open packet
            cmd_push       = 1'b1;
            cmd.is_start   = 1'b1;
            cmd.flag       = packet_flag;
            cmd.len_hi     = len[8];
            cmd.len_lo     = len[7:0];
            cmd.data       = data_byte;
            cmd.with_check = (param_count == 8'd0);
            cmd.sum        = start_sum;
            open_in        = (param_count != 8'd0);
            left_in        = param_count;
            sum_in         = start_sum;
         end else if (open_ff) begin
            cmd_push       = 1'b1;
            cmd.data       = data_byte;
            cmd.with_check = last_param;
            cmd.sum        = param_sum;
            left_in        = left_ff - 8'd1;
            sum_in         = param_sum;
            open_in        = !last_param;
         end
         // parameter with no packet open: dropped
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         left_ff <= 8'd0;
         sum_ff  <= 16'd0;
      end else begin
         open_ff <= open_in;
         left_ff <= left_in;
         sum_ff  <= sum_in;
      end
   end

endmodule

>>> src/scpf_cmd_queue.sv
module scpf_cmd_queue
   import scpf_pkg::*;
#(
   parameter int Depth = CMD_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  scpf_cmd_type din,
   output logic         full,
   input  logic         pop,
   output logic         valid,
   output scpf_cmd_type dout
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   scpf_cmd_type       slot_ff [Depth];
   logic [PtrW-1:0]    wr_ff, wr_in;
   logic [PtrW-1:0]    rd_ff, rd_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full    = (cnt_ff == CntW'(Depth));
   assign valid   = (cnt_ff != '0);
   assign dout    = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PtrW'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PtrW'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= din;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(Depth))
      else $error("command queue overfilled");

   a_no_lost_push: assert property (@(posedge clock) disable iff (reset)
      (push && full && !pop) |=> (cnt_ff == CntW'(Depth)))
      else $error("command queue count moved on a refused push");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (!valid && !push) |=> !valid)
      else $error("command queue became non-empty without a push");

endmodule

>>> src/scpf_back.sv
module scpf_back
   import scpf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [31:0]  device_address,
   input  logic         cmd_valid,
   input  scpf_cmd_type cmd,
   output logic         cmd_pop,
   output logic         empty,
   input  logic         pop,
   output logic [7:0]   tx_byte,
   output logic         end_of_packet
);

   scpf_state_type state_ff, state_in;
   scpf_cmd_type   cur_ff;

   // two-entry output buffer
   logic [7:0] ob_byte_ff [2];
   logic       ob_eop_ff  [2];
   logic       ob_wr_ff, ob_rd_ff;
   logic [1:0] ob_cnt_ff, ob_cnt_in;

   logic       can_emit, emit, take;
   logic [7:0] emit_byte;
   logic       emit_eop;

   assign can_emit = (ob_cnt_ff != 2'd2);
   assign emit     = (state_ff != ST_IDLE) && can_emit;
   assign take     = pop && !empty;
   assign cmd_pop  = (state_ff == ST_IDLE) && cmd_valid;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               state_in = cmd.is_start ? ST_HDR_HI : ST_DATA;
            end
         end
         ST_HDR_HI: if (can_emit) state_in = ST_HDR_LO;
         ST_HDR_LO: if (can_emit) state_in = ST_ADDR_3;
         ST_ADDR_3: if (can_emit) state_in = ST_ADDR_2;
         ST_ADDR_2: if (can_emit) state_in = ST_ADDR_1;
         ST_ADDR_1: if (can_emit) state_in = ST_ADDR_0;
         ST_ADDR_0: if (can_emit) state_in = ST_FLAG;
         ST_FLAG:   if (can_emit) state_in = ST_LEN_HI;
         ST_LEN_HI: if (can_emit) state_in = ST_LEN_LO;
         ST_LEN_LO: if (can_emit) state_in = ST_DATA;
         ST_DATA: begin
            if (can_emit) begin
               state_in = cur_ff.with_check ? ST_SUM_HI : ST_IDLE;
            end
         end
         ST_SUM_HI: if (can_emit) state_in = ST_SUM_LO;
         ST_SUM_LO: if (can_emit) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // byte select
   always_comb begin
      emit_eop = 1'b0;
      case (state_ff)
         ST_HDR_HI: emit_byte = HDR_HI;
         ST_HDR_LO: emit_byte = HDR_LO;
         ST_ADDR_3: emit_byte = device_address[31:24];
         ST_ADDR_2: emit_byte = device_address[23:16];
         ST_ADDR_1: emit_byte = device_address[15:8];
         ST_ADDR_0: emit_byte = device_address[7:0];
         ST_FLAG:   emit_byte = cur_ff.flag;
         ST_LEN_HI: emit_byte = {7'd0, cur_ff.len_hi};
         ST_LEN_LO: emit_byte = cur_ff.len_lo;
         ST_DATA:   emit_byte = cur_ff.data;
         ST_SUM_HI: emit_byte = cur_ff.sum[15:8];
         ST_SUM_LO: begin
            emit_byte = cur_ff.sum[7:0];
            emit_eop  = 1'b1;
         end
         default:   emit_byte = 8'd0;
      endcase
   end

   always_comb begin
      ob_cnt_in = ob_cnt_ff;
      if (emit && !take) begin
         ob_cnt_in = ob_cnt_ff + 2'd1;
      end else if (take && !emit) begin
         ob_cnt_in = ob_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ob_wr_ff  <= 1'b0;
         ob_rd_ff  <= 1'b0;
         ob_cnt_ff <= 2'd0;
      end else begin
         state_ff  <= state_in;
         ob_cnt_ff <= ob_cnt_in;
         if (emit) ob_wr_ff <= !ob_wr_ff;
         if (take) ob_rd_ff <= !ob_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cur_ff <= cmd;
      end
      if (emit) begin
         ob_byte_ff[ob_wr_ff] <= emit_byte;
         ob_eop_ff[ob_wr_ff]  <= emit_eop;
      end
   end

   assign empty         = (ob_cnt_ff == 2'd0);
   assign tx_byte       = ob_byte_ff[ob_rd_ff];
   assign end_of_packet = ob_eop_ff[ob_rd_ff];

   a_ob_bound: assert property (@(posedge clock) disable iff (reset)
      ob_cnt_ff <= 2'd2)
      else $error("output buffer overfilled");

   a_idle_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !cmd_valid) |=> (state_ff == ST_IDLE))
      else $error("sequencer left idle without a command");

   a_eop_closes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM_LO && emit) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not close after the checksum");

endmodule

>>> src/sensor_command_packet_framer.sv
// Command packet framer for a serial sensor link, one byte per result beat.
//
// Input channel (push/full): a start beat (req_func = 0) carries the flag,
// the command code and the parameter count; a parameter beat (req_func = 1)
// carries one parameter byte. A beat is taken when push is high and full low.
// Result channel (empty/pop): each beat is one byte to transmit; the low
// checksum byte is marked with rsp_end_of_packet.
// Configuration: APB-style port, device_address at byte address 0.
//
// Path: the first byte of an item passes the command queue, the sequencer
// state register and the output buffer before it is visible.
// Throughput: the back end sends one byte per cycle while the output buffer
// has room, and passes through idle to fetch each command. The front accepts
// one beat per cycle while the command queue has room.
//
// Reset clears the open-packet state, both queues and the sequencer and sets
// device_address to all ones. When the receiver holds off pop, the two-entry
// output buffer fills, the sequencer holds its byte, the command queue fills
// and full rises; nothing is lost.
module sensor_command_packet_framer
   import scpf_pkg::*;
#(
   parameter int CmdDepth = CMD_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  push,
   output logic                  full,
   input  logic                  req_func,
   input  logic [7:0]            req_data_byte,
   input  logic [7:0]            req_packet_flag,
   input  logic [7:0]            req_param_count,
   // result channel
   output logic                  empty,
   input  logic                  pop,
   output logic [7:0]            rsp_tx_byte,
   output logic                  rsp_end_of_packet,
   // configuration
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [31:0]  dev_addr_ff;
   logic         csr_sel_addr;
   logic         accept;
   logic         cmd_push, cmd_valid, cmd_pop, cmd_full;
   scpf_cmd_type cmd_in, cmd_out;

   // register decode: word index sits above the byte offset
   assign csr_sel_addr = (paddr[CSR_ADDR_W-1] == CSR_IDX_DEVICE_ADDRESS);
   assign pready       = 1'b1;
   assign prdata       = csr_sel_addr ? dev_addr_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= DEVICE_ADDRESS_RESET;
      end else if (psel && penable && pwrite && pready && csr_sel_addr) begin
         dev_addr_ff <= pwdata;
      end
   end

   assign full   = cmd_full;
   assign accept = push && !cmd_full;

   // front: classifies beats, keeps the running checksum
   scpf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .func        (req_func),
      .data_byte   (req_data_byte),
      .packet_flag (req_packet_flag),
      .param_count (req_param_count),
      .cmd_push    (cmd_push),
      .cmd         (cmd_in)
   );

   scpf_cmd_queue #(
      .Depth (CmdDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .din   (cmd_in),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .valid (cmd_valid),
      .dout  (cmd_out)
   );

   // back: expands commands into bytes
   scpf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .device_address (dev_addr_ff),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd_out),
      .cmd_pop        (cmd_pop),
      .empty          (empty),
      .pop            (pop),
      .tx_byte        (rsp_tx_byte),
      .end_of_packet  (rsp_end_of_packet)
   );

endmodule

>>> tb/tb_sensor_command_packet_framer.sv
`timescale 1ns / 1ps

// Self-checking bench for the sensor command packet framer.
//
// Input beats go in through push/full, output bytes come out through
// empty/pop. A predictor inside the bench keeps its own copy of the
// open-packet state and of device_address, and expands every accepted
// input beat into the bytes it should cause. Each popped byte is compared
// with the oldest of those. Both sides idle and stall at random.
module tb_sensor_command_packet_framer;
   import scpf_pkg::*;

   localparam int CYCLE_LIMIT  = 400_000;
   localparam int IDLE_GUARD   = 16;    // covers the back end work of a start
   localparam int RANDOM_BEATS = 140;
   localparam int CFG_EVERY    = 40;    // random beats between address changes
   localparam logic [CSR_ADDR_W-1:0] DEV_ADDR_OFFSET =
      CSR_ADDR_W'(4 * CSR_IDX_DEVICE_ADDRESS);

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       eop;
   } tx_beat_type;

   typedef enum logic {ROW_BEAT, ROW_ADDR} row_kind_type;

   // One line of the directed plan. Where typed is set, the bytes are
   // written out by hand, first byte in bytes[11]; a typed list that is not
   // empty always ends on the low checksum byte.
   typedef struct packed {
      row_kind_type     kind;
      logic             func;
      logic [7:0]       data;
      logic [7:0]       flag;
      logic [7:0]       count;
      logic [31:0]      addr;
      logic             typed;
      logic [3:0]       n_typed;
      logic [11:0][7:0] bytes;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        push;
   logic        full;
   logic        req_func;
   logic [7:0]  req_data_byte;
   logic [7:0]  req_packet_flag;
   logic [7:0]  req_param_count;
   logic        empty;
   logic        pop;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_end_of_packet;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // predictor state
   logic [31:0] addr_shadow;
   logic [7:0]  params_due;
   logic [15:0] sum_so_far;
   logic        pkt_open;

   tx_beat_type  tx_bytes_due [$];
   plan_row_type plan [$];

   int  errors = 0;
   int  beats_taken = 0;
   int  bytes_checked = 0;
   int  packets_closed = 0;
   int  addr_writes = 0;
   int  cycle_count = 0;
   bit  tx_calm = 1'b0;
   bit  rx_calm = 1'b0;

   sensor_command_packet_framer dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_func          (req_func),
      .req_data_byte     (req_data_byte),
      .req_packet_flag   (req_packet_flag),
      .req_param_count   (req_param_count),
      .empty             (empty),
      .pop               (pop),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_end_of_packet (rsp_end_of_packet),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #5 clock = ~clock;

   // Watchdog: well above the slowest legal run (every beat 12 bytes, every
   // byte behind a long pop stall, every beat behind a long push gap).
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d bytes outstanding", $time, tx_bytes_due.size());
         $display("tb_sensor_command_packet_framer: done, errors");
         $finish;
      end
   end

   // Mostly back to back, some short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void add_due(input logic [7:0] b, input logic e, input bit keep);
      if (keep) tx_bytes_due.push_back('{tx_byte: b, eop: e});
   endfunction

   function automatic void close_packet(input bit keep);
      add_due(sum_so_far[15:8], 1'b0, keep);
      add_due(sum_so_far[7:0], 1'b1, keep);
      pkt_open   = 1'b0;
      params_due = '0;
      sum_so_far = '0;
   endfunction

   // Expands one accepted beat into the bytes it should produce and moves
   // the predictor state on. With keep clear only the state moves.
   function automatic bit frame_beat(input logic func, input logic [7:0] data,
                                     input logic [7:0] flag, input logic [7:0] count,
                                     input bit keep);
      logic [15:0] len;
      len = 16'(count) + 16'd3;
      if (func == FUNC_START) begin
         // a start abandons any packet still open, no checksum for it
         add_due(HDR_HI, 1'b0, keep);
         add_due(HDR_LO, 1'b0, keep);
         add_due(addr_shadow[31:24], 1'b0, keep);
         add_due(addr_shadow[23:16], 1'b0, keep);
         add_due(addr_shadow[15:8], 1'b0, keep);
         add_due(addr_shadow[7:0], 1'b0, keep);
         add_due(flag, 1'b0, keep);
         add_due(len[15:8], 1'b0, keep);
         add_due(len[7:0], 1'b0, keep);
         add_due(data, 1'b0, keep);
         sum_so_far = 16'(flag) + 16'(len[15:8]) + 16'(len[7:0]) + 16'(data);
         params_due = count;
         pkt_open   = 1'b1;
         if (count == 8'd0) close_packet(keep);
         return 1'b0;
      end
      if (!pkt_open) return 1'b1;   // stray parameter: dropped
      add_due(data, 1'b0, keep);
      sum_so_far = sum_so_far + 16'(data);
      params_due = params_due - 8'd1;
      if (params_due == 8'd0) close_packet(keep);
      return 1'b0;
   endfunction

   function automatic plan_row_type beat_row(input logic func, input logic [7:0] data,
                                             input logic [7:0] flag,
                                             input logic [7:0] count,
                                             input logic typed, input logic [3:0] n,
                                             input logic [11:0][7:0] bytes);
      plan_row_type r;
      r = '0;
      r.kind    = ROW_BEAT;
      r.func    = func;
      r.data    = data;
      r.flag    = flag;
      r.count   = count;
      r.typed   = typed;
      r.n_typed = n;
      r.bytes   = bytes;
      return r;
   endfunction

   function automatic plan_row_type addr_row(input logic [31:0] v);
      plan_row_type r;
      r = '0;
      r.kind = ROW_ADDR;
      r.addr = v;
      return r;
   endfunction

   // Drops push and waits until every expected byte has gone, plus the
   // IDLE_GUARD margin for beats that leave nothing behind.
   task automatic wait_idle();
      @(negedge clock);
      push <= 1'b0;
      while (tx_bytes_due.size() != 0) @(posedge clock);
      repeat (IDLE_GUARD) @(posedge clock);
   endtask

   task automatic send_beat(input logic func, input logic [7:0] data,
                            input logic [7:0] flag, input logic [7:0] count,
                            input bit keep, output bit dropped);
      int gap;
      if ($urandom_range(99) < 4) tx_calm = !tx_calm;
      gap = tx_calm ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      push            <= 1'b1;
      req_func        <= func;
      req_data_byte   <= data;
      req_packet_flag <= flag;
      req_param_count <= count;
      @(posedge clock);
      while (full !== 1'b0) @(posedge clock);
      dropped = frame_beat(func, data, flag, count, keep);
      beats_taken++;
   endtask

   // Address change only with the framer idle, then read back.
   task automatic write_device_address(input logic [31:0] v);
      wait_idle();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= DEV_ADDR_OFFSET;
      pwdata  <= v;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      addr_shadow = v;
      addr_writes++;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      if (prdata !== v) begin
         errors++;
         $display("%0t: device_address read back: expected %08h, got %08h", $time, v, prdata);
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Result side: random pop stalls, with calm stretches; every byte popped
   // is checked against the oldest prediction.
   initial begin : rx_side
      int          stall_left;
      tx_beat_type want;
      stall_left = 0;
      pop = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) begin
            bytes_checked++;
            if (tx_bytes_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected byte: expected none, got tx_byte %02h eop %0b",
                        $time, rsp_tx_byte, rsp_end_of_packet);
            end else begin
               want = tx_bytes_due.pop_front();
               if (rsp_tx_byte !== want.tx_byte) begin
                  errors++;
                  $display("%0t: tx_byte: expected %02h, got %02h",
                           $time, want.tx_byte, rsp_tx_byte);
               end
               if (rsp_end_of_packet !== want.eop) begin
                  errors++;
                  $display("%0t: end_of_packet: expected %0b, got %0b",
                           $time, want.eop, rsp_end_of_packet);
               end
               if (want.eop) packets_closed++;
            end
         end
         @(negedge clock);
         if ($urandom_range(99) == 0) rx_calm = !rx_calm;
         if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
         end else begin
            pop <= 1'b1;
            if (!rx_calm && $urandom_range(99) < 30) stall_left = pick_gap();
         end
      end
   end

   initial begin : tx_side
      bit         dropped;
      int         k;
      int         rand_beats;
      int         next_cfg;
      int         roll;
      int         n_par;
      logic [7:0] cnt;

      reset           = 1'b1;
      push            = 1'b0;
      req_func        = FUNC_START;
      req_data_byte   = '0;
      req_packet_flag = '0;
      req_param_count = '0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      addr_shadow     = DEVICE_ADDRESS_RESET;
      params_due      = '0;
      sum_so_far      = '0;
      pkt_open        = 1'b0;

      // Directed plan. Hand-typed rows: the reset address, the extreme
      // flag/command, the all-zero address, and parameters with no packet open.
      plan.push_back(beat_row(FUNC_START, 8'h00, 8'h01, 8'd0, 1'b1, 4'd12,
         {8'hEF, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h03, 8'h00,
          8'h00, 8'h04}));
      plan.push_back(beat_row(FUNC_PARAM, 8'hAA, 8'h55, 8'hAA, 1'b1, 4'd0, '0));
      plan.push_back(beat_row(FUNC_START, 8'hFF, 8'hFF, 8'd0, 1'b1, 4'd12,
         {8'hEF, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h03, 8'hFF,
          8'h02, 8'h01}));
      plan.push_back(addr_row(32'h0000_0000));
      plan.push_back(beat_row(FUNC_START, 8'h00, 8'h00, 8'd0, 1'b1, 4'd12,
         {8'hEF, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h00,
          8'h00, 8'h03}));
      plan.push_back(addr_row(32'h1234_5678));
      // short packet, parameters at both extremes
      plan.push_back(beat_row(FUNC_START, 8'h0C, 8'h5A, 8'd2, 1'b0, 4'd0, '0));
      plan.push_back(beat_row(FUNC_PARAM, 8'h00, 8'hFF, 8'hFF, 1'b0, 4'd0, '0));
      plan.push_back(beat_row(FUNC_PARAM, 8'hFF, 8'h00, 8'h00, 1'b0, 4'd0, '0));
      // parameter after the packet has closed: dropped
      plan.push_back(beat_row(FUNC_PARAM, 8'h33, 8'h12, 8'h03, 1'b1, 4'd0, '0));
      // largest count, length 0x0102; abandoned by the next start
      plan.push_back(beat_row(FUNC_START, 8'h31, 8'h01, 8'd255, 1'b0, 4'd0, '0));
      plan.push_back(beat_row(FUNC_PARAM, 8'h80, 8'h00, 8'h00, 1'b0, 4'd0, '0));
      plan.push_back(beat_row(FUNC_PARAM, 8'h7F, 8'h00, 8'h00, 1'b0, 4'd0, '0));
      plan.push_back(beat_row(FUNC_START, 8'h21, 8'h02, 8'd1, 1'b0, 4'd0, '0));
      plan.push_back(beat_row(FUNC_PARAM, 8'hFF, 8'h00, 8'h00, 1'b0, 4'd0, '0));
      // length low byte wraps to 0x00 with high byte 0x01
      plan.push_back(beat_row(FUNC_START, 8'h05, 8'h01, 8'd253, 1'b0, 4'd0, '0));
      plan.push_back(beat_row(FUNC_START, 8'h3C, 8'h07, 8'd4, 1'b0, 4'd0, '0));
      for (k = 0; k < 4; k++)
         plan.push_back(beat_row(FUNC_PARAM, 8'hFF, 8'h00, 8'h00, 1'b0, 4'd0, '0));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_ADDR) begin
            write_device_address(plan[i].addr);
         end else begin
            send_beat(plan[i].func, plan[i].data, plan[i].flag, plan[i].count,
                      !plan[i].typed, dropped);
            if (plan[i].typed)
               for (k = 0; k < plan[i].n_typed; k++)
                  add_due(plan[i].bytes[11 - k], k == plan[i].n_typed - 1, 1'b1);
         end
      end

      // Random part: mostly complete packets with small counts, some
      // abandoned part way, a few huge counts cut short, and stray beats.
      rand_beats = 0;
      next_cfg   = 0;
      while (rand_beats < RANDOM_BEATS) begin
         if (rand_beats >= next_cfg) begin
            write_device_address($urandom);
            next_cfg += CFG_EVERY;
         end
         roll = $urandom_range(99);
         if (roll < 80)      cnt = 8'($urandom_range(0, 6));
         else if (roll < 95) cnt = 8'($urandom_range(7, 20));
         else                cnt = 8'($urandom_range(250, 255));
         n_par = cnt;
         if (cnt > 20)
            n_par = $urandom_range(0, 8);
         else if (cnt != 0 && $urandom_range(99) < 10)
            n_par = $urandom_range(0, cnt - 1);
         send_beat(FUNC_START, 8'($urandom), 8'($urandom), cnt, 1'b1, dropped);
         rand_beats++;
         for (k = 0; k < n_par; k++) begin
            send_beat(FUNC_PARAM, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1, dropped);
            if (!dropped) rand_beats++;
         end
         if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(1, 2)) begin
               send_beat(FUNC_PARAM, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1,
                         dropped);
               if (!dropped) rand_beats++;
            end
         end
      end

      wait_idle();
      if (tx_bytes_due.size() != 0) begin
         errors++;
         $display("%0t: %0d expected bytes never arrived", $time, tx_bytes_due.size());
      end
      $display("covered %0d input beats, %0d output bytes, %0d closed packets",
               beats_taken, bytes_checked, packets_closed);
      $display("device_address written %0d times after the all-ones reset value, incl. all-zero",
               addr_writes);
      if (errors == 0) begin
         $display("tb_sensor_command_packet_framer: done, clean");
      end else begin
         $display("tb_sensor_command_packet_framer: done, errors");
      end
      $finish;
   end

endmodule
